// ===== src/logo_alpha_blend_pixel_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the alpha blend pixel block
// Shared property wrappers used by the port-level checker.
// ----------------------------------------------------------------------------
`ifndef LOGO_ALPHA_BLEND_PIXEL_ASSERT_SVH
`define LOGO_ALPHA_BLEND_PIXEL_ASSERT_SVH

// Property checked on every clock edge outside of reset.
`define LABP_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("labp assertion failed");

// Property checked on every clock edge, reset included.
`define LABP_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("labp assertion failed");

`endif

// ===== src/labp_pkg.sv =====
// ----------------------------------------------------------------------------
// labp_pkg
// Widths, blend constants and shared types of the alpha blend pixel block.
// ----------------------------------------------------------------------------
package labp_pkg;

   localparam int ChanW    = 8;
   localparam int NumLanes = 3;
   localparam int PixW     = 32;
   localparam int ColorW   = NumLanes * ChanW;
   localparam int OpacityW = 7;
   localparam int WeightW  = 15;

   localparam logic [OpacityW-1:0] OpacityReset = 7'd100;
   localparam logic [OpacityW-1:0] OpacityFull  = 7'd100;
   localparam logic [ChanW-1:0]    TranspFull   = 8'hFF;
   localparam logic [ChanW-1:0]    TranspNone   = 8'h00;
   localparam logic [ChanW-1:0]    ChanMax      = 8'hFF;

   // Blend denominator: 100 percent times 255 transparency steps.
   localparam logic [14:0] BlendDen  = 15'd25500;
   // floor(2^32 / 25500); the quotient estimate is low by at most one.
   localparam logic [17:0] RecipMul  = 18'd168430;
   localparam int          RecipShift = 32;
   // 256 * 25500: any numerator at or above this clamps to full scale.
   localparam logic [22:0] SatLimit  = 23'd6528000;

   typedef enum logic [1:0] {
      MODE_BLEND,
      MODE_PASS,
      MODE_COPY
   } labp_mode_type;

   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
      logic s4;
   } labp_stage_en_type;

endpackage

// ===== src/labp_lane.sv =====
// ----------------------------------------------------------------------------
// labp_lane
// Four-stage blend of one 8-bit color channel: weighted difference, sum,
// reciprocal quotient estimate, then correction and clamp.
// ----------------------------------------------------------------------------
module labp_lane (
   input  logic                         clock,
   input  labp_pkg::labp_stage_en_type  stage_en,
   input  logic [7:0]                   dest_chan,
   input  logic [7:0]                   ovl_chan,
   input  logic [14:0]                  weight,
   output logic [7:0]                   blend_chan
);
   import labp_pkg::*;

   logic signed [8:0]  diff;
   logic signed [24:0] prod_in;
   logic [22:0]        base_in;
   logic signed [24:0] prod_ff;
   logic [22:0]        base_ff;

   logic signed [24:0] num_in;
   logic signed [24:0] num_ff;

   logic               neg_in;
   logic               sat_in;
   logic [39:0]        recip_prod;
   logic [7:0]         qest_in;
   logic               neg_ff;
   logic               sat_ff;
   logic [7:0]         qest_ff;
   logic [22:0]        numlow_ff;

   logic [22:0]        qden;
   logic [22:0]        rem;
   logic               bump;
   logic [7:0]         quot;
   logic [7:0]         blend_in;
   logic [7:0]         blend_ff;

   // Stage 1: (o - d) * weight and d * 25500.
   assign diff    = $signed({1'b0, ovl_chan}) - $signed({1'b0, dest_chan});
   assign prod_in = diff * $signed({1'b0, weight});
   assign base_in = {15'd0, dest_chan} * {8'd0, BlendDen};

   // Stage 2: full numerator.
   assign num_in = $signed({2'b00, base_ff}) + prod_ff;

   // Stage 3: range checks and quotient estimate by reciprocal.
   assign neg_in     = num_ff[24];
   assign sat_in     = !num_ff[24] && (num_ff[23:0] >= {1'b0, SatLimit});
   assign recip_prod = {17'd0, num_ff[22:0]} * {22'd0, RecipMul};
   assign qest_in    = recip_prod[RecipShift+ChanW-1:RecipShift];

   // Stage 4: the estimate may be one short; fix it with the remainder.
   assign qden = {15'd0, qest_ff} * {8'd0, BlendDen};
   assign rem  = numlow_ff - qden;
   assign bump = rem >= {8'd0, BlendDen};
   assign quot = qest_ff + {7'd0, bump};

   always_comb begin
      if (neg_ff) begin
         blend_in = '0;
      end else if (sat_ff) begin
         blend_in = ChanMax;
      end else begin
         blend_in = quot;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en.s1) begin
         prod_ff <= prod_in;
         base_ff <= base_in;
      end
      if (stage_en.s2) begin
         num_ff <= num_in;
      end
      if (stage_en.s3) begin
         neg_ff    <= neg_in;
         sat_ff    <= sat_in;
         qest_ff   <= qest_in;
         numlow_ff <= num_ff[22:0];
      end
      if (stage_en.s4) begin
         blend_ff <= blend_in;
      end
   end

   assign blend_chan = blend_ff;

endmodule

// ===== src/labp_merge.sv =====
// ----------------------------------------------------------------------------
// labp_merge
// Combines the three lane results with the pass-through and copy cases
// into the output pixel word.
// ----------------------------------------------------------------------------
module labp_merge (
   input  labp_pkg::labp_mode_type  mode,
   input  logic [31:0]              dest_pixel,
   input  logic [23:0]              ovl_color,
   input  logic [23:0]              blend_color,
   output logic [31:0]              result_pixel
);
   import labp_pkg::*;

   always_comb begin
      case (mode)
         MODE_PASS:  result_pixel = dest_pixel;
         MODE_COPY:  result_pixel = {8'd0, ovl_color};
         MODE_BLEND: result_pixel = {8'd0, blend_color};
         default:    result_pixel = {8'd0, blend_color};
      endcase
   end

endmodule

// ===== src/logo_alpha_blend_pixel.sv =====
// ----------------------------------------------------------------------------
// logo_alpha_blend_pixel
// Blends an overlay pixel onto a destination pixel with per-pixel
// transparency and a global opacity, one lane per color channel.
//
//   Channel | Direction | Handshake            | Payload
//   --------+-----------+----------------------+-------------------------------
//   req     | in        | req_valid/req_stall  | req_dest_pixel, req_overlay_pixel
//   rsp     | out       | rsp_valid/rsp_stall  | rsp_result_pixel
//   csr     | in        | csr_wr_en            | csr_wr_data (opacity percent)
//
// One beat is taken every clock while req_stall is low; each accepted beat
// passes through the input stage, the four lane stages (weight product,
// sum, reciprocal multiply, correction) and the output register.
// Each stage advances whenever the one after it is empty or moving, so
// bubbles close up while the output is stalled.
// Reset clears all valid flags and sets the opacity to 100 percent.
// ----------------------------------------------------------------------------
module logo_alpha_blend_pixel (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_dest_pixel,
   input  logic [31:0] req_overlay_pixel,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_result_pixel,
   input  logic        csr_wr_en,
   input  logic [6:0]  csr_wr_data
);
   import labp_pkg::*;

   localparam int NumStages = 5;

   logic [OpacityW-1:0]  csr_opacity_percent_ff;

   logic [NumStages-1:0] valid_ff;
   logic [NumStages:0]   ready;
   logic                 rsp_valid_ff;
   logic [PixW-1:0]      rsp_result_pixel_ff;

   logic [PixW-1:0]      dest_pipe_ff  [NumStages];
   logic [ColorW-1:0]    color_pipe_ff [NumStages];
   labp_mode_type        mode_pipe_ff  [NumStages];
   logic [WeightW-1:0]   weight_ff;

   logic [ChanW-1:0]     transp;
   logic [ChanW-1:0]     transp_inv;
   logic [WeightW-1:0]   weight_in;
   labp_mode_type        mode_in;

   labp_stage_en_type    stage_en;
   logic [ColorW-1:0]    blend_color;
   logic [PixW-1:0]      merged_pixel;

   assign transp     = req_overlay_pixel[31:24];
   assign transp_inv = ~transp;
   assign weight_in  = {8'd0, csr_opacity_percent_ff} * {7'd0, transp_inv};

   always_comb begin
      if (transp == TranspFull) begin
         mode_in = MODE_PASS;
      end else if (csr_opacity_percent_ff == OpacityFull && transp == TranspNone) begin
         mode_in = MODE_COPY;
      end else begin
         mode_in = MODE_BLEND;
      end
   end

   // A stage may load when it is empty or its content moves on.
   assign ready[NumStages] = !rsp_valid_ff || !rsp_stall;
   for (genvar k = 0; k < NumStages; k++) begin : g_ready
      assign ready[k] = !valid_ff[k] || ready[k+1];
   end

   assign req_stall = !ready[0];

   assign stage_en.s1 = ready[1];
   assign stage_en.s2 = ready[2];
   assign stage_en.s3 = ready[3];
   assign stage_en.s4 = ready[4];

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_opacity_percent_ff <= OpacityReset;
         valid_ff               <= '0;
         rsp_valid_ff           <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            csr_opacity_percent_ff <= csr_wr_data;
         end
         if (ready[0]) begin
            valid_ff[0] <= req_valid;
         end
         for (int k = 1; k < NumStages; k++) begin
            if (ready[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
         if (ready[NumStages]) begin
            rsp_valid_ff <= valid_ff[NumStages-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ready[0]) begin
         dest_pipe_ff[0]  <= req_dest_pixel;
         color_pipe_ff[0] <= req_overlay_pixel[ColorW-1:0];
         mode_pipe_ff[0]  <= mode_in;
         weight_ff        <= weight_in;
      end
      for (int k = 1; k < NumStages; k++) begin
         if (ready[k]) begin
            dest_pipe_ff[k]  <= dest_pipe_ff[k-1];
            color_pipe_ff[k] <= color_pipe_ff[k-1];
            mode_pipe_ff[k]  <= mode_pipe_ff[k-1];
         end
      end
      if (ready[NumStages]) begin
         rsp_result_pixel_ff <= merged_pixel;
      end
   end

   for (genvar g = 0; g < NumLanes; g++) begin : g_lane
      labp_lane u_lane (
         .clock      (clock),
         .stage_en   (stage_en),
         .dest_chan  (dest_pipe_ff[0][g*ChanW +: ChanW]),
         .ovl_chan   (color_pipe_ff[0][g*ChanW +: ChanW]),
         .weight     (weight_ff),
         .blend_chan (blend_color[g*ChanW +: ChanW])
      );
   end

   labp_merge u_merge (
      .mode         (mode_pipe_ff[NumStages-1]),
      .dest_pixel   (dest_pipe_ff[NumStages-1]),
      .ovl_color    (color_pipe_ff[NumStages-1]),
      .blend_color  (blend_color),
      .result_pixel (merged_pixel)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_pixel = rsp_result_pixel_ff;

endmodule

// ===== src/labp_checker.sv =====
// ----------------------------------------------------------------------------
// labp_checker
// Port-level checks of the alpha blend pixel block, bound to the top level.
// ----------------------------------------------------------------------------
`include "logo_alpha_blend_pixel_assert.svh"

module labp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_result_pixel
);

   // The output register is empty right after reset.
   `LABP_ASSERT_ALWAYS(a_reset_empties, clock, reset |=> !rsp_valid)

   // When the output can drain, every stage can move, so input is taken.
   `LABP_ASSERT(a_no_stall_when_draining, clock, reset, (!rsp_valid || !rsp_stall) |-> !req_stall)

   // A stalled result stays offered.
   `LABP_ASSERT(a_rsp_valid_holds, clock, reset, (rsp_valid && rsp_stall) |=> rsp_valid)

   // A stalled result keeps its value.
   `LABP_ASSERT(a_rsp_data_holds, clock, reset, (rsp_valid && rsp_stall) |=> $stable(rsp_result_pixel))

endmodule

bind logo_alpha_blend_pixel labp_checker u_labp_checker (.*);

// ===== tb/sv/tb_logo_alpha_blend_pixel.sv =====
// ----------------------------------------------------------------------------
// tb_logo_alpha_blend_pixel
// Self-checking bench for the alpha blend pixel block. Each beat is predicted
// from the opacity register and the two pixels, and every result beat is
// compared in order. Traffic arrives in random bursts against a randomly
// stalling receiver, with one long receiver hold-off that fills the pipeline.
// ----------------------------------------------------------------------------
module tb_logo_alpha_blend_pixel;
   timeunit 1ns;
   timeprecision 1ps;

   import labp_pkg::*;

   localparam int DrainCycles = 12;
   localparam int HoldCycles  = 80;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [PixW-1:0]     req_dest_pixel;
   logic [PixW-1:0]     req_overlay_pixel;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [PixW-1:0]     rsp_result_pixel;
   logic                csr_wr_en;
   logic [OpacityW-1:0] csr_wr_data;

   logic [PixW-1:0]     pending_pixels[$];
   logic [OpacityW-1:0] opacity_now;
   int                  mismatch_count;
   bit                  hold_rsp_request;

   logo_alpha_blend_pixel uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_dest_pixel    (req_dest_pixel),
      .req_overlay_pixel (req_overlay_pixel),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_result_pixel  (rsp_result_pixel),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #1_000_000;
      $display("TEST FAILED");
      $finish;
   end

   // Exact integer blend of one pixel pair at the given opacity.
   function automatic logic [PixW-1:0] blend_pixel(logic [PixW-1:0] dest,
                                                   logic [PixW-1:0] ovl,
                                                   logic [OpacityW-1:0] opacity);
      logic [ChanW-1:0] transp;
      logic [PixW-1:0]  res;
      longint           num;
      longint           quo;
      longint           weight;
      longint           d_chan;
      longint           o_chan;
      transp = ovl[PixW-1 -: ChanW];
      res    = '0;
      if (transp == TranspFull) begin
         res = dest;
      end else if (opacity == OpacityFull && transp == TranspNone) begin
         res = {{(PixW-ColorW){1'b0}}, ovl[ColorW-1:0]};
      end else begin
         weight = longint'(opacity) * (255 - longint'(transp));
         for (int lane = 0; lane < NumLanes; lane++) begin
            d_chan = longint'(dest[lane*ChanW +: ChanW]);
            o_chan = longint'(ovl[lane*ChanW +: ChanW]);
            num    = d_chan * longint'(BlendDen) + (o_chan - d_chan) * weight;
            if (num < 0) begin
               quo = 0;
            end else begin
               quo = num / longint'(BlendDen);
               if (quo > 255) quo = 255;
            end
            res[lane*ChanW +: ChanW] = quo[ChanW-1:0];
         end
      end
      return res;
   endfunction

   // Offers one beat and returns once it has been taken. Valid stays high, so
   // back-to-back calls make a burst with no bubble.
   task automatic send_pixel(input logic [PixW-1:0] dest, input logic [PixW-1:0] ovl);
      req_valid         <= 1'b1;
      req_dest_pixel    <= dest;
      req_overlay_pixel <= ovl;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_pixels.push_back(blend_pixel(dest, ovl, opacity_now));
   endtask

   task automatic idle_sender(input int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // The register is only written once every result is back and the
   // pipeline has had time to empty.
   task automatic set_opacity(input logic [OpacityW-1:0] value);
      req_valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      opacity_now  = value;
      @(posedge clock);
   endtask

   function automatic logic [PixW-1:0] random_overlay();
      logic [PixW-1:0] ovl;
      ovl = $urandom;
      case ($urandom_range(0, 7))
         0: ovl[PixW-1 -: ChanW] = TranspNone;
         1: ovl[PixW-1 -: ChanW] = TranspFull;
         2: ovl[PixW-1 -: ChanW] = 8'd1;
         3: ovl[PixW-1 -: ChanW] = 8'd254;
         default: ;
      endcase
      return ovl;
   endfunction

   task automatic send_random_bursts(input int count);
      int sent;
      int burst;
      sent = 0;
      while (sent < count) begin
         burst = $urandom_range(1, 24);
         for (int i = 0; i < burst && sent < count; i++) begin
            send_pixel($urandom, random_overlay());
            sent++;
         end
         if ($urandom_range(0, 3) != 0) idle_sender($urandom_range(1, 6));
      end
   endtask

   // Pass-through, plain copy and ordinary blends at the reset opacity.
   task automatic test_reset_opacity_cases();
      send_pixel(32'hA5123456, 32'hFF89ABCD);
      send_pixel(32'hFFFFFFFF, 32'hFFFFFFFF);
      send_pixel(32'h00000000, 32'hFF000000);
      send_pixel(32'h7F102030, 32'h00C0D0E0);
      send_pixel(32'hFFFFFFFF, 32'h00000000);
      send_pixel(32'h00000000, 32'h00FFFFFF);
      send_pixel(32'hDE00FF80, 32'h80FF0040);
      send_pixel(32'h00FFFFFF, 32'h01000000);
      send_pixel(32'h00000000, 32'hFEFFFFFF);
      idle_sender(3);
   endtask

   // No opacity, full-scale extrapolation, the first value past 100, then 1 and 100.
   task automatic test_opacity_extremes();
      set_opacity(7'd0);
      send_pixel(32'h12345678, 32'h00FFFFFF);
      send_pixel(32'hFFFFFFFF, 32'h00000000);
      send_pixel(32'h00ABCDEF, 32'hFF000000);
      set_opacity(7'd127);
      send_pixel(32'h00FF00FF, 32'h0000FF00);
      send_pixel(32'h00000000, 32'h00FFFFFF);
      send_pixel(32'h00808080, 32'h40C04000);
      send_pixel(32'h55AA55AA, 32'hFF123456);
      set_opacity(7'd101);
      send_pixel(32'h00F00F80, 32'h000FF07F);
      send_pixel(32'h00102030, 32'h00FFFFFF);
      set_opacity(7'd1);
      send_pixel(32'h00000000, 32'h00FFFFFF);
      send_pixel(32'h00FFFFFF, 32'hFE000000);
      set_opacity(7'd100);
      send_pixel(32'hCC00FF00, 32'h00FF00FF);
      idle_sender(2);
   endtask

   // The receiver holds off for a long stretch while beats keep coming,
   // so the pipeline fills and the input has to stall.
   task automatic test_backpressure();
      set_opacity(7'd63);
      hold_rsp_request = 1'b1;
      for (int i = 0; i < 40; i++) send_pixel($urandom, random_overlay());
      idle_sender(1);
   endtask

   task automatic test_random_sweep();
      logic [OpacityW-1:0] value;
      for (int phase = 0; phase < 13; phase++) begin
         case ($urandom_range(0, 5))
            0: value = OpacityFull;
            1: value = 7'd0;
            2: value = 7'($urandom_range(101, 127));
            default: value = 7'($urandom_range(0, 100));
         endcase
         set_opacity(value);
         send_random_bursts(100);
      end
      idle_sender(1);
   endtask

   // Receiver stall pattern: runs of different densities, including runs
   // with no stall at all.
   initial begin
      int mode;
      int left;
      mode = 0;
      left = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_rsp_request) begin
            hold_rsp_request = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HoldCycles) @(posedge clock);
            rsp_stall <= 1'b0;
            left = 0;
         end else begin
            if (left == 0) begin
               mode = $urandom_range(0, 3);
               left = $urandom_range(10, 80);
            end
            left--;
            case (mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 3) == 0);
               2: rsp_stall <= ($urandom_range(0, 3) != 0);
               default: rsp_stall <= (left % 3 == 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin
      logic [PixW-1:0] expected;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_pixels.size() == 0) begin
            $error("unexpected result beat: result_pixel %h", rsp_result_pixel);
            mismatch_count++;
         end else begin
            expected = pending_pixels.pop_front();
            if (rsp_result_pixel !== expected) begin
               $error("result_pixel mismatch: expected %h, actual %h",
                      expected, rsp_result_pixel);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      int waited;
      mismatch_count    = 0;
      hold_rsp_request  = 1'b0;
      opacity_now       = OpacityReset;
      reset             <= 1'b1;
      req_valid         <= 1'b0;
      req_dest_pixel    <= '0;
      req_overlay_pixel <= '0;
      csr_wr_en         <= 1'b0;
      csr_wr_data       <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_opacity_cases();
      test_opacity_extremes();
      test_backpressure();
      test_random_sweep();

      req_valid <= 1'b0;
      waited = 0;
      while (pending_pixels.size() != 0 && waited < 2000) begin
         @(posedge clock);
         waited++;
      end
      if (pending_pixels.size() != 0) begin
         $error("%0d expected result beats never arrived", pending_pixels.size());
         mismatch_count++;
      end
      repeat (DrainCycles) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+src
src/labp_pkg.sv
src/labp_lane.sv
src/labp_merge.sv
src/logo_alpha_blend_pixel.sv
src/labp_checker.sv
tb/sv/tb_logo_alpha_blend_pixel.sv
